// ----- hdl/snms_pkg.sv -----
// ----------------------------------------------------------------------------
// snms_pkg: shared types and constants of the Sobel edge thinning block
// Word formats, fixed widths, register indexes and direction codes that the
// datapath and the port checker share.
// ----------------------------------------------------------------------------
package snms_pkg;

   // Fixed field widths.
   localparam int PIXEL_BITS    = 8;
   localparam int MAG_BITS      = 11;
   localparam int CFG_BITS      = 12;
   localparam int ROW_BITS      = 12;
   localparam int RING_BITS     = 2;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int MIN_SIZE      = 3;

   // Arithmetic widths that follow from the pixel width.
   localparam int GRAD_BITS  = PIXEL_BITS + 4;     // signed Sobel response
   localparam int ABS_BITS   = PIXEL_BITS + 2;     // magnitude of one response
   localparam int ROOT_BITS  = PIXEL_BITS + 3;     // square root of the sum
   localparam int SUM_BITS   = 2 * ROOT_BITS;      // sum of squares
   localparam int REM_BITS   = ROOT_BITS + 3;      // square root remainder
   localparam int STEP_BITS  = $clog2(ROOT_BITS);
   localparam int FRAC_BITS  = 15;
   localparam int PROD_BITS  = ABS_BITS + FRAC_BITS;

   // tan(22.5 deg) in Q0.15.
   localparam logic [FRAC_BITS-1:0] TAN22_Q15 = 15'd13573;
   localparam logic [MAG_BITS-1:0]  MAG_SAT   = 11'h7FF;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
   localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 12'd480;

   // Gradient direction codes.
   localparam logic [1:0] DIR_HORZ      = 2'd0;
   localparam logic [1:0] DIR_DIAG_DOWN = 2'd1;
   localparam logic [1:0] DIR_VERT      = 2'd2;
   localparam logic [1:0] DIR_DIAG_UP   = 2'd3;

   // Window tap positions along one axis.
   localparam logic [1:0] TAP_LO  = 2'd0;
   localparam logic [1:0] TAP_MID = 2'd1;
   localparam logic [1:0] TAP_HI  = 2'd2;

   // Input and result words.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  flush;
   } req_word_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] edge_strength;
      logic                frame_last;
   } rsp_word_type;

endpackage

// ----- hdl/snms_ram.sv -----
// ----------------------------------------------------------------------------
// snms_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module snms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/sobel_gradient_nonmax_suppression_top.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_nonmax_suppression_top: Sobel gradient with edge thinning
// Grey pixels enter in raster order on the req_ channel, one word per pixel.
// Each word forms the 3x3 Sobel gradient of the pixel one row and one column
// back (reflect-101 borders), its rounded magnitude and its direction sector,
// and then thins the pixel two rows and two columns back against its two
// neighbors along that direction. Border pixels pass their raw magnitude.
// The rsp_ channel carries one result word per input word once two rows and
// two columns have gone in; frame_last marks the last result of a frame.
// After the last pixel, words with flush set drain the remaining results.
// Frame size is to be written on the csr_ port while idle; the block itself
// does not enforce this. It is taken at the first pixel of the next frame.
// A word that computes a gradient and a result makes nine reads of the pixel
// line store through its single read port and runs an eleven-step bit-serial
// square root before the next word is accepted. req_stall is high while
// a word is worked on. A finished result waits in the output register while
// the next word is already accepted; the block stalls only if that register
// is still full when the following result is ready.
// Reset returns to the first pixel of a frame with a 640 x 480 size and an
// empty output register. The line stores need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_gradient_nonmax_suppression_top #(
   parameter int MAX_WIDTH = snms_pkg::MAX_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  snms_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output snms_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [snms_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [snms_pkg::CFG_BITS-1:0]          csr_data
);

   import snms_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WW     = COL_W + 1;
   localparam int ADDR_W = RING_BITS + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_GRAD_RD  = 4'd2;
   localparam logic [3:0] ST_GRAD_ACC = 4'd3;
   localparam logic [3:0] ST_GRAD_ABS = 4'd4;
   localparam logic [3:0] ST_GRAD_MUL = 4'd5;
   localparam logic [3:0] ST_GRAD_SUM = 4'd6;
   localparam logic [3:0] ST_SQRT     = 4'd7;
   localparam logic [3:0] ST_GRAD_WB  = 4'd8;
   localparam logic [3:0] ST_SUP_RD0  = 4'd9;
   localparam logic [3:0] ST_SUP_RD1  = 4'd10;
   localparam logic [3:0] ST_SUP_RD2  = 4'd11;
   localparam logic [3:0] ST_SUP_RD3  = 4'd12;
   localparam logic [3:0] ST_OUT      = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CFG_BITS-1:0]   frame_width_ff, frame_height_ff;
   logic [WW-1:0]         act_w_ff, act_w_in;
   logic [ROW_BITS-1:0]   act_h_ff, act_h_in;
   logic [PIXEL_BITS-1:0] pixel_ff;
   logic                  flush_ff;

   logic [ROW_BITS-1:0]   rm_ff, rq_ff;
   logic [COL_W-1:0]      cm_ff, cq_ff;
   logic                  do_sup_ff, last_ff;

   logic [1:0]            tap_row_ff, tap_col_ff, acc_row_ff, acc_col_ff;
   logic                  acc_en_ff;
   logic signed [GRAD_BITS-1:0] gx_ff, gy_ff;
   logic [ABS_BITS-1:0]   ax_ff, ay_ff;
   logic [2*ABS_BITS-1:0] sqx_ff, sqy_ff;
   logic [PROD_BITS-1:0]  tx_ff, ty_ff;
   logic [SUM_BITS-1:0]   sum_sh_ff;
   logic [ROOT_BITS-1:0]  root_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [1:0]            dir_grad_ff, dir_sup_ff;
   logic [MAG_BITS-1:0]   cmag_ff, nbr_a_ff, res_ff;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   // Memory ports.
   logic                  pix_wr_en, mag_wr_en;
   logic [ADDR_W-1:0]     pix_rd_addr, mag_rd_addr;
   logic [PIXEL_BITS-1:0] pix_rd_data;
   logic [MAG_BITS-1:0]   mag_rd_data, mag_wr_data;
   logic [1:0]            dir_rd_data;

   // Position decode of the current word.
   logic                  in_frame, grad_ok, do_grad, sup_ok, is_last, col_wrap;
   logic [ROW_BITS-1:0]   rm_d, rq_d;
   logic [COL_W-1:0]      cm_d, cq_d, w_m1, w_m2;
   logic [ROW_BITS-1:0]   h_m1;
   logic                  border;

   // Gradient datapath signals.
   logic [ROW_BITS-1:0]   tap_row_sel;
   logic [COL_W-1:0]      tap_col_sel;
   logic signed [GRAD_BITS-1:0] pix_ext, pix_w, ngx, ngy;
   logic [REM_BITS-1:0]   rem_sh, trial;
   logic [ROOT_BITS:0]    mag_full;
   logic                  accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign w_m1 = COL_W'(act_w_ff - WW'(1));
   assign w_m2 = COL_W'(act_w_ff - WW'(2));
   assign h_m1 = act_h_ff - ROW_BITS'(1);

   // Neighbor address along a direction; second selects the neighbor on the lower row (the right one for horizontal).
   function automatic logic [ADDR_W-1:0] nbr_addr(input logic [1:0] dir,
                                                   input logic second,
                                                   input logic [ROW_BITS-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [RING_BITS-1:0] up, dn, rs;
      logic [COL_W-1:0]     lf, rt, cs;
      up = r[RING_BITS-1:0] - RING_BITS'(1);
      dn = r[RING_BITS-1:0] + RING_BITS'(1);
      lf = c - COL_W'(1);
      rt = c + COL_W'(1);
      unique case (dir)
         DIR_HORZ: begin
            rs = r[RING_BITS-1:0];
            cs = second ? rt : lf;
         end
         DIR_DIAG_DOWN: begin
            rs = second ? dn : up;
            cs = second ? rt : lf;
         end
         DIR_VERT: begin
            rs = second ? dn : up;
            cs = c;
         end
         default: begin
            rs = second ? dn : up;
            cs = second ? lf : rt;
         end
      endcase
      return {rs, cs};
   endfunction

   // Where the current word sits and which work it causes.
   always_comb begin
      in_frame = (row_ff < act_h_ff);
      col_wrap = ((WW'(col_ff) + WW'(1)) == act_w_ff);
      if (col_ff != '0) begin
         grad_ok = (row_ff >= ROW_BITS'(1));
         rm_d    = row_ff - ROW_BITS'(1);
         cm_d    = col_ff - COL_W'(1);
      end else begin
         grad_ok = (row_ff >= ROW_BITS'(2));
         rm_d    = row_ff - ROW_BITS'(2);
         cm_d    = w_m1;
      end
      do_grad = grad_ok && (rm_d < act_h_ff);
      if (col_ff >= COL_W'(2)) begin
         sup_ok = (row_ff >= ROW_BITS'(2));
         rq_d   = row_ff - ROW_BITS'(2);
         cq_d   = col_ff - COL_W'(2);
      end else if (col_ff == COL_W'(1)) begin
         sup_ok = (row_ff >= ROW_BITS'(3));
         rq_d   = row_ff - ROW_BITS'(3);
         cq_d   = w_m1;
      end else begin
         sup_ok = (row_ff >= ROW_BITS'(3));
         rq_d   = row_ff - ROW_BITS'(3);
         cq_d   = w_m2;
      end
      is_last = (rq_d == h_m1) && (cq_d == w_m1);
      border  = (rq_ff == '0) || (cq_ff == '0) || (rq_ff == h_m1) || (cq_ff == w_m1);
   end

   // Frame size clamp, taken at the first pixel of a frame.
   always_comb begin
      if (frame_width_ff < CFG_BITS'(MIN_SIZE)) begin
         act_w_in = WW'(MIN_SIZE);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         act_w_in = WW'(MAX_WIDTH);
      end else begin
         act_w_in = WW'(frame_width_ff);
      end
      if (frame_height_ff < CFG_BITS'(MIN_SIZE)) begin
         act_h_in = ROW_BITS'(MIN_SIZE);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         act_h_in = ROW_BITS'(MAX_HEIGHT);
      end else begin
         act_h_in = ROW_BITS'(frame_height_ff);
      end
   end

   // Window tap address with reflect-101 borders.
   always_comb begin
      unique case (tap_row_ff)
         TAP_LO:  tap_row_sel = (rm_ff == '0) ? ROW_BITS'(1) : rm_ff - ROW_BITS'(1);
         TAP_MID: tap_row_sel = rm_ff;
         default: tap_row_sel = (rm_ff == h_m1) ? act_h_ff - ROW_BITS'(2)
                                                : rm_ff + ROW_BITS'(1);
      endcase
      unique case (tap_col_ff)
         TAP_LO:  tap_col_sel = (cm_ff == '0) ? COL_W'(1) : cm_ff - COL_W'(1);
         TAP_MID: tap_col_sel = cm_ff;
         default: tap_col_sel = (cm_ff == w_m1) ? w_m2 : cm_ff + COL_W'(1);
      endcase
      pix_rd_addr = {tap_row_sel[RING_BITS-1:0], tap_col_sel};
   end

   // Tap weights: the middle row or column counts twice.
   assign pix_ext = $signed({(GRAD_BITS-PIXEL_BITS)'(0), pix_rd_data});
   assign pix_w   = pix_ext <<< 1;
   assign ngx     = -gx_ff;
   assign ngy     = -gy_ff;

   // One square root step: bring down two bits, try to subtract.
   assign rem_sh   = {rem_ff[REM_BITS-3:0], sum_sh_ff[SUM_BITS-1 -: 2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign mag_full = {1'b0, root_ff} + {{ROOT_BITS{1'b0}},
                                        (rem_ff > REM_BITS'(root_ff))};
   assign mag_wr_data = (mag_full > (ROOT_BITS+1)'(MAG_SAT)) ? MAG_SAT
                                                             : MAG_BITS'(mag_full);

   // Magnitude store read address per sequencer step.
   always_comb begin
      unique case (state_ff)
         ST_SUP_RD1: mag_rd_addr = nbr_addr(dir_rd_data, 1'b0, rq_ff, cq_ff);
         ST_SUP_RD2: mag_rd_addr = nbr_addr(dir_sup_ff, 1'b1, rq_ff, cq_ff);
         default:    mag_rd_addr = {rq_ff[RING_BITS-1:0], cq_ff};
      endcase
   end

   assign pix_wr_en = (state_ff == ST_DECODE) && in_frame && !flush_ff;
   assign mag_wr_en = (state_ff == ST_GRAD_WB);

   // Sequencer and position.
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (in_frame && flush_ff) begin
               state_in = ST_IDLE;
            end else begin
               if (sup_ok && is_last) begin
                  row_in = '0;
                  col_in = '0;
               end else if (col_wrap) begin
                  row_in = row_ff + ROW_BITS'(1);
                  col_in = '0;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               if (do_grad) begin
                  state_in = ST_GRAD_RD;
               end else if (sup_ok) begin
                  state_in = ST_SUP_RD0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_GRAD_RD: begin
            if (tap_row_ff == TAP_HI && tap_col_ff == TAP_HI) begin
               state_in = ST_GRAD_ACC;
            end
         end
         ST_GRAD_ACC: state_in = ST_GRAD_ABS;
         ST_GRAD_ABS: state_in = ST_GRAD_MUL;
         ST_GRAD_MUL: state_in = ST_GRAD_SUM;
         ST_GRAD_SUM: state_in = ST_SQRT;
         ST_SQRT: begin
            if (step_ff == '0) begin
               state_in = ST_GRAD_WB;
            end
         end
         ST_GRAD_WB: state_in = do_sup_ff ? ST_SUP_RD0 : ST_IDLE;
         ST_SUP_RD0: state_in = ST_SUP_RD1;
         ST_SUP_RD1: state_in = border ? ST_OUT : ST_SUP_RD2;
         ST_SUP_RD2: state_in = ST_SUP_RD3;
         ST_SUP_RD3: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_ff          <= '0;
         col_ff          <= '0;
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
         act_w_ff        <= WW'(640);
         act_h_ff        <= ROW_BITS'(480);
         acc_en_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         acc_en_ff <= (state_ff == ST_GRAD_RD);
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept && row_ff == '0 && col_ff == '0 && !req_word.flush) begin
            act_w_ff <= act_w_in;
            act_h_ff <= act_h_in;
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_word.pixel;
         flush_ff <= req_word.flush;
      end

      // Work decode of the accepted word.
      if (state_ff == ST_DECODE) begin
         rm_ff      <= rm_d;
         cm_ff      <= cm_d;
         rq_ff      <= rq_d;
         cq_ff      <= cq_d;
         do_sup_ff  <= sup_ok;
         last_ff    <= is_last;
         tap_row_ff <= TAP_LO;
         tap_col_ff <= TAP_LO;
         gx_ff      <= '0;
         gy_ff      <= '0;
      end

      // Walk the nine window taps.
      if (state_ff == ST_GRAD_RD) begin
         if (tap_col_ff == TAP_HI) begin
            tap_col_ff <= TAP_LO;
            tap_row_ff <= tap_row_ff + 2'd1;
         end else begin
            tap_col_ff <= tap_col_ff + 2'd1;
         end
      end
      acc_row_ff <= tap_row_ff;
      acc_col_ff <= tap_col_ff;

      // Accumulate Gx over left and right columns, Gy over top and bottom rows.
      if (acc_en_ff) begin
         if (acc_col_ff == TAP_LO) begin
            gx_ff <= gx_ff - ((acc_row_ff == TAP_MID) ? pix_w : pix_ext);
         end else if (acc_col_ff == TAP_HI) begin
            gx_ff <= gx_ff + ((acc_row_ff == TAP_MID) ? pix_w : pix_ext);
         end
         if (acc_row_ff == TAP_LO) begin
            gy_ff <= gy_ff - ((acc_col_ff == TAP_MID) ? pix_w : pix_ext);
         end else if (acc_row_ff == TAP_HI) begin
            gy_ff <= gy_ff + ((acc_col_ff == TAP_MID) ? pix_w : pix_ext);
         end
      end

      // Absolute values.
      if (state_ff == ST_GRAD_ABS) begin
         ax_ff <= gx_ff[GRAD_BITS-1] ? ngx[ABS_BITS-1:0] : gx_ff[ABS_BITS-1:0];
         ay_ff <= gy_ff[GRAD_BITS-1] ? ngy[ABS_BITS-1:0] : gy_ff[ABS_BITS-1:0];
      end

      // Squares and the tangent products.
      if (state_ff == ST_GRAD_MUL) begin
         sqx_ff <= (2*ABS_BITS)'(ax_ff) * (2*ABS_BITS)'(ax_ff);
         sqy_ff <= (2*ABS_BITS)'(ay_ff) * (2*ABS_BITS)'(ay_ff);
         tx_ff  <= PROD_BITS'(ax_ff) * PROD_BITS'(TAN22_Q15);
         ty_ff  <= PROD_BITS'(ay_ff) * PROD_BITS'(TAN22_Q15);
      end

      // Sum of squares, direction sector, and square root start.
      if (state_ff == ST_GRAD_SUM) begin
         sum_sh_ff <= SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
         root_ff   <= '0;
         rem_ff    <= '0;
         step_ff   <= STEP_BITS'(ROOT_BITS - 1);
         if ({ay_ff, FRAC_BITS'(0)} <= tx_ff) begin
            dir_grad_ff <= DIR_HORZ;
         end else if ({ax_ff, FRAC_BITS'(0)} <= ty_ff) begin
            dir_grad_ff <= DIR_VERT;
         end else if (gx_ff[GRAD_BITS-1] == gy_ff[GRAD_BITS-1]) begin
            dir_grad_ff <= DIR_DIAG_DOWN;
         end else begin
            dir_grad_ff <= DIR_DIAG_UP;
         end
      end

      // One root bit per cycle.
      if (state_ff == ST_SQRT) begin
         sum_sh_ff <= sum_sh_ff << 2;
         step_ff   <= step_ff - STEP_BITS'(1);
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end

      // Thinning against the two neighbors along the direction.
      if (state_ff == ST_SUP_RD1) begin
         cmag_ff    <= mag_rd_data;
         dir_sup_ff <= dir_rd_data;
         res_ff     <= mag_rd_data;
      end
      if (state_ff == ST_SUP_RD2) begin
         nbr_a_ff <= mag_rd_data;
      end
      if (state_ff == ST_SUP_RD3) begin
         res_ff <= (cmag_ff >= nbr_a_ff && cmag_ff >= mag_rd_data) ? cmag_ff : '0;
      end

      // Output register.
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_word_ff.edge_strength <= res_ff;
         rsp_word_ff.frame_last    <= last_ff;
      end
   end

   // Pixel line store: four rows.
   snms_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_pixel_lines (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr ({row_ff[RING_BITS-1:0], col_ff}),
      .wr_data (pixel_ff),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   // Magnitude line store: four rows.
   snms_ram #(
      .WIDTH (MAG_BITS),
      .DEPTH (DEPTH)
   ) u_magnitude_lines (
      .clock   (clock),
      .wr_en   (mag_wr_en),
      .wr_addr ({rm_ff[RING_BITS-1:0], cm_ff}),
      .wr_data (mag_wr_data),
      .rd_addr (mag_rd_addr),
      .rd_data (mag_rd_data)
   );

   // Direction line store: four rows.
   snms_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_direction_line (
      .clock   (clock),
      .wr_en   (mag_wr_en),
      .wr_addr ({rm_ff[RING_BITS-1:0], cm_ff}),
      .wr_data (dir_grad_ff),
      .rd_addr ({rq_ff[RING_BITS-1:0], cq_ff}),
      .rd_data (dir_rd_data)
   );

endmodule

// ----- hdl/snms_checker.sv -----
// ----------------------------------------------------------------------------
// snms_checker: port-level checks of the Sobel edge thinning block
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module snms_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input snms_pkg::rsp_word_type rsp_word
);

   import snms_pkg::*;

   // A held result keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // Reset leaves the block ready and the output empty.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // An accepted word keeps the input stalled while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after acceptance");

   // A new result only comes out of a word in progress.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a word in progress");

endmodule

bind sobel_gradient_nonmax_suppression_top snms_checker u_snms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
